// ===== rtl/core/lcpo_free_surface_area_assert.svh =====
// assertion macros for the lcpo surface area top level
`ifndef LCPO_FREE_SURFACE_AREA_ASSERT_SVH
`define LCPO_FREE_SURFACE_AREA_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LCPO_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcpo assertion failed");

// next-cycle implication, checked out of reset
`define LCPO_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcpo assertion failed");

`endif

// ===== rtl/core/lcpo_pkg.sv =====
// shared types and constants for the lcpo surface area block
package lcpo_pkg;

    localparam int ATOM_W       = 10;
    localparam int SLOT_W       = 5;
    localparam int MAX_OVERLAPS = 32;
    localparam int TYPE_W       = 6;
    localparam int TYPE_IN_W    = 7;
    localparam int TYPE_COUNT   = 64;
    localparam int CNT_W        = 6;
    localparam int AREA_W       = 32;
    localparam int REC_W        = 1 + TYPE_W + CNT_W;
    localparam int COEF_AW      = TYPE_W + 2;
    localparam int PAIR_AW      = ATOM_W + SLOT_W;
    localparam int REL_W        = 17;
    localparam int SUM31_W      = 31;
    localparam int SUM47_W      = 47;

    typedef enum logic [1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_LOAD_ATOM = 2'd1,
        CMD_LOAD_SLOT = 2'd2,
        CMD_COMPUTE   = 2'd3
    } cmd_t;

    // memory read kinds, tagged at issue and acted on when data returns
    typedef enum logic [2:0] {
        RK_NONE, RK_REC, RK_LIST, RK_SLOT, RK_NCOUNT, RK_SCAN, RK_ONE, RK_COEF
    } rk_t;

    typedef enum logic [1:0] {
        VOP_NONE, VOP_ZERO, VOP_SURF, VOP_TERM
    } vop_t;

    typedef enum logic [1:0] {
        MUL_NONE, MUL_PROD, MUL_HI, MUL_LO
    } mul_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_REC, ST_RECW, ST_BRANCH, ST_ONE, ST_ONEW, ST_LIST,
        ST_SLOT, ST_SLOTW, ST_NCNT, ST_NCNTW, ST_SCAN, ST_SCANW, ST_PROD,
        ST_PRODACC, ST_CLAMP, ST_COEF, ST_COEFW, ST_MHI, ST_MLO, ST_WACC,
        ST_DIV, ST_DIVIT, ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        rk_t  rk;
        vop_t v_op;
        mul_t mul;
        logic prod_acc;
        logic j_next;
        logic clamp;
        logic c_next;
        logic div_setup;
        logic div_step;
        logic out_load;
    } ctrl_t;

    typedef struct packed {
        logic buried;
        logic ni_zero;
        logic ni_one;
        logic list_last;
        logic scan_empty;
        logic scan_last;
        logic j_last;
        logic c_last;
        logic div_busy;
    } status_t;

    typedef struct packed {
        logic               comp_valid;
        logic [SUM47_W-1:0] prod;
        logic [SUM31_W-1:0] shared;
        logic [SUM31_W-1:0] pair;
        logic [REL_W-1:0]   rel;
    } result_t;

endpackage

// ===== rtl/core/lcpo_free_surface_area.sv =====
// top level of the lcpo free surface area block
//
//  channel | dir | handshake          | contents
//  s_      | in  | s_tvalid/s_tready  | tuser command, tdata load or compute fields
//  m_      | out | m_tvalid/m_tready  | tuser components flag, tdata ratio and sums
//
// a load item is taken while the sequencer is idle and gives no result.
// a compute item is taken and the atom record is read; a buried or overlap-free atom goes
// straight to the division, and an atom with one overlap reads that slot first. the weighted
// branch copies the overlap list, then for each slot reads the slot and its neighbor's count
// and scans the neighbor's slots one read at a time, then clamps and weighs the components;
// last come the bit-serial division and the output load.
// reset clears the sequencer and valid flags only; stores hold garbage until loaded.
// a full output register holds the next result until m_tready frees it.
module lcpo_free_surface_area import lcpo_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // atom_index, slot_index, neighbor_index, atom_type, coeff_select,
    // data_value, buried_flag, overlap_count, zero pad
    input  logic [79:0]  s_tdata,
    // command
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // relative_area, sum_pair_areas, sum_shared_areas, sum_area_products, zero pad
    output logic [127:0] m_tdata,
    // components_valid
    output logic [0:0]   m_tuser
);

`include "lcpo_free_surface_area_assert.svh"

    ctrl_t   ctrl;
    status_t status;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    out_free;
    logic    in_accept;
    cmd_t    in_cmd;

    assign in_cmd    = cmd_t'(s_tuser);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    lcpo_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .in_cmd(in_cmd),
        .status(status), .out_free(out_free), .s_tready(s_tready), .ctrl(ctrl)
    );

    lcpo_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .in_accept(in_accept), .in_cmd(in_cmd),
        .in_atom(s_tdata[9:0]), .in_slot(s_tdata[14:10]), .in_nbr(s_tdata[24:15]),
        .in_type(s_tdata[31:25]), .in_sel(s_tdata[33:32]), .in_data(s_tdata[65:34]),
        .in_buried(s_tdata[66]), .in_count(s_tdata[72:67]),
        .ctrl(ctrl), .status(status), .result(result)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b0, out_reg.prod, out_reg.shared, out_reg.pair, out_reg.rel};
    assign m_tuser  = out_reg.comp_valid;

    // checks
    `LCPO_ASSERT_IMP(a_load_when_free, aclk, aresetn, ctrl.out_load, out_free)
    `LCPO_ASSERT_NEXT(a_load_shows, aclk, aresetn, ctrl.out_load, m_tvalid)
    `LCPO_ASSERT_IMP(a_idle_no_div, aclk, aresetn, s_tready, !status.div_busy)

endmodule

// ===== rtl/core/lcpo_ram.sv =====
// generic single-write, single-read ram with registered read data
module lcpo_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/lcpo_ctrl.sv =====
// sequencer for load, neighbor walk, weighting and division
module lcpo_ctrl import lcpo_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  cmd_t    in_cmd,
    input  status_t status,
    input  logic    out_free,
    output logic    s_tready,
    output ctrl_t   ctrl
);

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        ctrl.rk    = RK_NONE;
        ctrl.v_op  = VOP_NONE;
        ctrl.mul   = MUL_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid && in_cmd == CMD_COMPUTE) begin
                    ctrl.start = 1'b1;
                    state_next = ST_REC;
                end
            end
            ST_REC: begin
                ctrl.rk    = RK_REC;
                state_next = ST_RECW;
            end
            ST_RECW: state_next = ST_BRANCH;
            ST_BRANCH: begin
                if (status.buried) begin
                    ctrl.v_op  = VOP_ZERO;
                    state_next = ST_DIV;
                end else if (status.ni_zero) begin
                    ctrl.v_op  = VOP_SURF;
                    state_next = ST_DIV;
                end else if (status.ni_one) begin
                    state_next = ST_ONE;
                end else begin
                    state_next = ST_LIST;
                end
            end
            ST_ONE: begin
                ctrl.rk    = RK_ONE;
                state_next = ST_ONEW;
            end
            ST_ONEW: state_next = ST_DIV;
            // copy the atom's neighbor list into the lanes
            ST_LIST: begin
                ctrl.rk = RK_LIST;
                if (status.list_last) begin
                    state_next = ST_SLOT;
                end
            end
            ST_SLOT: begin
                ctrl.rk    = RK_SLOT;
                state_next = ST_SLOTW;
            end
            ST_SLOTW: state_next = ST_NCNT;
            ST_NCNT: begin
                ctrl.rk    = RK_NCOUNT;
                state_next = ST_NCNTW;
            end
            ST_NCNTW: state_next = ST_SCAN;
            // walk the neighbor's slots, one read per cycle
            ST_SCAN: begin
                if (status.scan_empty) begin
                    state_next = ST_PROD;
                end else begin
                    ctrl.rk = RK_SCAN;
                    if (status.scan_last) begin
                        state_next = ST_SCANW;
                    end
                end
            end
            ST_SCANW: state_next = ST_PROD;
            ST_PROD: begin
                ctrl.mul   = MUL_PROD;
                state_next = ST_PRODACC;
            end
            ST_PRODACC: begin
                ctrl.prod_acc = 1'b1;
                ctrl.j_next   = 1'b1;
                state_next    = status.j_last ? ST_CLAMP : ST_SLOT;
            end
            ST_CLAMP: begin
                ctrl.clamp = 1'b1;
                state_next = ST_COEF;
            end
            // weigh the four components
            ST_COEF: begin
                ctrl.rk    = RK_COEF;
                state_next = ST_COEFW;
            end
            ST_COEFW: state_next = ST_MHI;
            ST_MHI: begin
                ctrl.mul   = MUL_HI;
                state_next = ST_MLO;
            end
            ST_MLO: begin
                ctrl.mul   = MUL_LO;
                state_next = ST_WACC;
            end
            ST_WACC: begin
                ctrl.v_op   = VOP_TERM;
                ctrl.c_next = 1'b1;
                state_next  = status.c_last ? ST_DIV : ST_COEF;
            end
            ST_DIV: begin
                ctrl.div_setup = 1'b1;
                state_next     = ST_DIVIT;
            end
            ST_DIVIT: begin
                if (status.div_busy) begin
                    ctrl.div_step = 1'b1;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/lcpo_dp.sv =====
// stores, neighbor lanes, shared multiplier and divider
module lcpo_dp import lcpo_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_accept,
    input  cmd_t                 in_cmd,
    input  logic [ATOM_W-1:0]    in_atom,
    input  logic [SLOT_W-1:0]    in_slot,
    input  logic [ATOM_W-1:0]    in_nbr,
    input  logic [TYPE_IN_W-1:0] in_type,
    input  logic [1:0]           in_sel,
    input  logic [AREA_W-1:0]    in_data,
    input  logic                 in_buried,
    input  logic [CNT_W-1:0]     in_count,
    input  ctrl_t                ctrl,
    output status_t              status,
    output result_t              result
);

    localparam int SCD_W    = 38;
    localparam int PAIR_W   = 38;
    localparam int SHARED_W = 43;
    localparam int PROD_W   = 54;
    localparam int V_W      = 56;
    localparam int MA_W     = 33;
    localparam int MUL_W    = 65;
    localparam int WIDE_W   = 82;
    localparam int TERM_W   = WIDE_W - 28;
    localparam int REM_W    = 34;
    localparam int DCNT_W   = 5;
    localparam logic [DCNT_W-1:0] DIV_STEPS = 5'd17;
    localparam logic [REL_W-1:0]  RATIO_MAX = '1;

    // write side of the stores
    logic               coef_we, atom_we, slot_we;
    logic [COEF_AW-1:0] coef_waddr;
    logic [TYPE_W-1:0]  type_clamped;
    logic [CNT_W-1:0]   cnt_clamped;
    logic [REC_W-1:0]   rec_wdata;

    // read side
    logic [COEF_AW-1:0] coef_raddr;
    logic [ATOM_W-1:0]  rec_raddr;
    logic [PAIR_AW-1:0] pair_raddr;
    logic [AREA_W-1:0]  coef_q, surf_q, area_q;
    logic [REC_W-1:0]   rec_q;
    logic [ATOM_W-1:0]  nbr_q;

    rk_t                rk_d_reg;
    logic [SLOT_W-1:0]  idx_d_reg;
    logic [ATOM_W-1:0]  atom_reg, nb_reg;
    logic [SLOT_W-1:0]  l_reg, j_reg, k_reg;
    logic [1:0]         c_reg;
    logic [CNT_W-1:0]   ni_reg, nn_reg;
    logic               buried_reg;
    logic [TYPE_W-1:0]  type_reg;
    logic [AREA_W-1:0]  surf_reg, aij_reg, coef_reg;
    logic [ATOM_W-1:0]  lane_reg [MAX_OVERLAPS];
    logic signed [SCD_W-1:0]    scd_reg;
    logic signed [PAIR_W-1:0]   pair_reg;
    logic signed [SHARED_W-1:0] shared_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic [SUM31_W-1:0] surf_c_reg, pair_c_reg, shared_c_reg;
    logic [SUM47_W-1:0] prod_c_reg;
    logic               comp_valid_reg;
    logic signed [MUL_W-1:0] mul_reg, phi_reg;
    logic signed [V_W-1:0]   v_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [REL_W-1:0]   q_reg;
    logic [DCNT_W-1:0]  div_cnt_reg;

    logic                    member;
    logic [AREA_W-1:0]       scd_c;
    logic [SUM47_W-1:0]      x_sel;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [AREA_W-1:0] mul_b;
    logic signed [WIDE_W-1:0] wide_sum;
    logic signed [V_W-1:0]   term;
    logic signed [V_W-1:0]   surf_ext;
    logic [REM_W-1:0]        surf_rem;

    // load decode
    always_comb begin
        coef_we    = in_accept && in_cmd == CMD_LOAD_COEF &&
                     in_type != '0 && in_type <= TYPE_IN_W'(TYPE_COUNT);
        atom_we    = in_accept && in_cmd == CMD_LOAD_ATOM;
        slot_we    = in_accept && in_cmd == CMD_LOAD_SLOT;
        coef_waddr = {TYPE_W'(in_type - 1'b1), in_sel};
        if (in_type == '0) begin
            type_clamped = '0;
        end else if (in_type > TYPE_IN_W'(TYPE_COUNT)) begin
            type_clamped = TYPE_W'(TYPE_COUNT - 1);
        end else begin
            type_clamped = TYPE_W'(in_type - 1'b1);
        end
        cnt_clamped = (in_count > CNT_W'(MAX_OVERLAPS)) ? CNT_W'(MAX_OVERLAPS) : in_count;
        rec_wdata   = {in_buried, type_clamped, cnt_clamped};
    end

    // read addresses by issued kind
    always_comb begin
        coef_raddr = {type_reg, c_reg};
        rec_raddr  = (ctrl.rk == RK_NCOUNT) ? nb_reg : atom_reg;
        case (ctrl.rk)
            RK_SLOT: pair_raddr = {atom_reg, j_reg};
            RK_SCAN: pair_raddr = {nb_reg, k_reg};
            RK_ONE:  pair_raddr = {atom_reg, SLOT_W'(0)};
            default: pair_raddr = {atom_reg, l_reg};
        endcase
    end

    lcpo_ram #(.WIDTH(AREA_W), .DEPTH(TYPE_COUNT * 4)) u_coef_ram (
        .aclk(aclk), .we(coef_we), .waddr(coef_waddr), .wdata(in_data),
        .raddr(coef_raddr), .rdata(coef_q)
    );

    lcpo_ram #(.WIDTH(AREA_W), .DEPTH(1 << ATOM_W)) u_surf_ram (
        .aclk(aclk), .we(atom_we), .waddr(in_atom), .wdata(in_data),
        .raddr(rec_raddr), .rdata(surf_q)
    );

    lcpo_ram #(.WIDTH(REC_W), .DEPTH(1 << ATOM_W)) u_rec_ram (
        .aclk(aclk), .we(atom_we), .waddr(in_atom), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_q)
    );

    lcpo_ram #(.WIDTH(ATOM_W), .DEPTH(1 << PAIR_AW)) u_nbr_ram (
        .aclk(aclk), .we(slot_we), .waddr({in_atom, in_slot}), .wdata(in_nbr),
        .raddr(pair_raddr), .rdata(nbr_q)
    );

    lcpo_ram #(.WIDTH(AREA_W), .DEPTH(1 << PAIR_AW)) u_area_ram (
        .aclk(aclk), .we(slot_we), .waddr({in_atom, in_slot}), .wdata(in_data),
        .raddr(pair_raddr), .rdata(area_q)
    );

    // membership of the returned neighbor in the atom's own list
    always_comb begin
        member = 1'b0;
        for (int i = 0; i < MAX_OVERLAPS; i++) begin
            if (lane_reg[i] == nbr_q && CNT_W'(i) < ni_reg) begin
                member = 1'b1;
            end
        end
    end

    // multiplier operands and weighted term
    always_comb begin
        if (scd_reg > SCD_W'(signed'(32'sh7FFFFFFF))) begin
            scd_c = 32'h7FFFFFFF;
        end else if (scd_reg < SCD_W'(signed'(-32'sh80000000))) begin
            scd_c = 32'h80000000;
        end else begin
            scd_c = scd_reg[AREA_W-1:0];
        end
        case (c_reg)
            2'd0:    x_sel = {16'b0, surf_c_reg};
            2'd1:    x_sel = {16'b0, pair_c_reg};
            2'd2:    x_sel = {16'b0, shared_c_reg};
            default: x_sel = prod_c_reg;
        endcase
        case (ctrl.mul)
            MUL_PROD: begin
                mul_a = {aij_reg[AREA_W-1], aij_reg};
                mul_b = scd_c;
            end
            MUL_HI: begin
                mul_a = {2'b0, x_sel[SUM47_W-1:16]};
                mul_b = coef_reg;
            end
            default: begin
                mul_a = {17'b0, x_sel[15:0]};
                mul_b = coef_reg;
            end
        endcase
        wide_sum = {phi_reg[MUL_W-1], phi_reg, 16'b0} +
                   {{(WIDE_W - MUL_W){mul_reg[MUL_W-1]}}, mul_reg};
        term     = {{(V_W - TERM_W){wide_sum[WIDE_W-1]}}, wide_sum[WIDE_W-1:28]};
        surf_ext = {{(V_W - AREA_W){surf_reg[AREA_W-1]}}, surf_reg};
        surf_rem = {2'b0, surf_reg};
    end

    // control-side registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rk_d_reg    <= RK_NONE;
            div_cnt_reg <= '0;
        end else begin
            rk_d_reg <= ctrl.rk;
            if (ctrl.div_setup) begin
                div_cnt_reg <= (v_reg > 0 && surf_reg != '0 && !surf_reg[AREA_W-1] &&
                                v_reg < (surf_ext <<< 1)) ? DIV_STEPS : '0;
            end else if (ctrl.div_step) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            atom_reg       <= in_atom;
            l_reg          <= '0;
            j_reg          <= '0;
            c_reg          <= '0;
            pair_reg       <= '0;
            shared_reg     <= '0;
            prod_reg       <= '0;
            comp_valid_reg <= 1'b0;
        end
        // issue side
        case (ctrl.rk)
            RK_LIST: begin
                idx_d_reg <= l_reg;
                l_reg     <= l_reg + 1'b1;
            end
            RK_SLOT: begin
                k_reg   <= '0;
                scd_reg <= '0;
            end
            RK_SCAN: k_reg <= k_reg + 1'b1;
            default: ;
        endcase
        // return side
        case (rk_d_reg)
            RK_REC: begin
                surf_reg   <= surf_q;
                buried_reg <= rec_q[REC_W-1];
                type_reg   <= rec_q[REC_W-2:CNT_W];
                ni_reg     <= rec_q[CNT_W-1:0];
            end
            RK_LIST: lane_reg[idx_d_reg] <= nbr_q;
            RK_SLOT: begin
                aij_reg  <= area_q;
                nb_reg   <= nbr_q;
                pair_reg <= pair_reg + {{(PAIR_W - AREA_W){area_q[AREA_W-1]}}, area_q};
            end
            RK_NCOUNT: nn_reg <= rec_q[CNT_W-1:0];
            RK_SCAN: begin
                if (member) begin
                    scd_reg <= scd_reg + {{(SCD_W - AREA_W){area_q[AREA_W-1]}}, area_q};
                end
            end
            RK_ONE: v_reg <= surf_ext - {{(V_W - AREA_W){area_q[AREA_W-1]}}, area_q};
            RK_COEF: coef_reg <= coef_q;
            default: ;
        endcase
        // shared multiplier
        if (ctrl.mul != MUL_NONE) begin
            mul_reg <= mul_a * mul_b;
        end
        if (ctrl.mul == MUL_LO) begin
            phi_reg <= mul_reg;
        end
        // per-slot accumulation
        if (ctrl.prod_acc) begin
            shared_reg <= shared_reg + {{(SHARED_W - SCD_W){scd_reg[SCD_W-1]}}, scd_reg};
            prod_reg   <= prod_reg +
                          {{(PROD_W - (MUL_W - 16)){mul_reg[MUL_W-1]}}, mul_reg[MUL_W-1:16]};
        end
        if (ctrl.j_next) begin
            j_reg <= j_reg + 1'b1;
        end
        // clamp the components
        if (ctrl.clamp) begin
            surf_c_reg     <= surf_reg[AREA_W-1] ? '0 : surf_reg[SUM31_W-1:0];
            pair_c_reg     <= pair_reg[PAIR_W-1] ? '0 :
                              (pair_reg[PAIR_W-2:SUM31_W] != '0) ? '1 :
                              pair_reg[SUM31_W-1:0];
            shared_c_reg   <= shared_reg[SHARED_W-1] ? '0 :
                              (shared_reg[SHARED_W-2:SUM31_W] != '0) ? '1 :
                              shared_reg[SUM31_W-1:0];
            prod_c_reg     <= prod_reg[PROD_W-1] ? '0 :
                              (prod_reg[PROD_W-2:SUM47_W] != '0) ? '1 :
                              prod_reg[SUM47_W-1:0];
            comp_valid_reg <= 1'b1;
            v_reg          <= '0;
        end
        case (ctrl.v_op)
            VOP_ZERO: v_reg <= '0;
            VOP_SURF: v_reg <= surf_ext;
            VOP_TERM: v_reg <= v_reg + term;
            default: ;
        endcase
        if (ctrl.c_next) begin
            c_reg <= c_reg + 1'b1;
        end
        // ratio: special cases, then restoring division
        if (ctrl.div_setup) begin
            rem_reg <= v_reg[REM_W-1:0];
            if (v_reg <= 0 || surf_reg[AREA_W-1]) begin
                q_reg <= '0;
            end else if (surf_reg == '0 || v_reg >= (surf_ext <<< 1)) begin
                q_reg <= RATIO_MAX;
            end else begin
                q_reg <= '0;
            end
        end else if (ctrl.div_step) begin
            if (rem_reg >= surf_rem) begin
                rem_reg <= (rem_reg - surf_rem) << 1;
                q_reg   <= {q_reg[REL_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_reg << 1;
                q_reg   <= {q_reg[REL_W-2:0], 1'b0};
            end
        end
    end

    // status to the sequencer
    always_comb begin
        status.buried     = buried_reg;
        status.ni_zero    = ni_reg == '0;
        status.ni_one     = ni_reg == CNT_W'(1);
        status.list_last  = {1'b0, l_reg} == ni_reg - 1'b1;
        status.scan_empty = nn_reg == '0;
        status.scan_last  = {1'b0, k_reg} == nn_reg - 1'b1;
        status.j_last     = {1'b0, j_reg} == ni_reg - 1'b1;
        status.c_last     = c_reg == 2'd3;
        status.div_busy   = div_cnt_reg != '0;
    end

    // result bundle
    always_comb begin
        result.rel        = q_reg;
        result.comp_valid = comp_valid_reg;
        result.pair       = comp_valid_reg ? pair_c_reg : '0;
        result.shared     = comp_valid_reg ? shared_c_reg : '0;
        result.prod       = comp_valid_reg ? prod_c_reg : '0;
    end

endmodule

// ===== tb/lcpo_free_surface_area_checker.sv =====
// checker for the lcpo surface area block: mirrors its stores, predicts each compute result
`timescale 1ns / 1ps

module lcpo_free_surface_area_checker import lcpo_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [79:0]  s_tdata,
    input  logic [1:0]   s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,
    input  logic [0:0]   m_tuser,
    output int           errors,
    output int           pending,
    output int           compared
);

    localparam longint SAT31     = 64'd2147483647;
    localparam longint SAT47     = 64'd140737488355327;
    localparam longint RATIO_TOP = 64'd131071;

    // mirrored stores
    int          coef_mem [TYPE_COUNT*4];
    int          surf_mem [1024];
    bit          bur_mem  [1024];
    logic [5:0]  type_mem [1024];
    logic [5:0]  cnt_mem  [1024];
    logic [9:0]  nbr_mem  [1024*MAX_OVERLAPS];
    int          area_mem [1024*MAX_OVERLAPS];

    result_t     area_q[$];

    initial begin
        errors   = 0;
        pending  = 0;
        compared = 0;
    end

    // floor(x * c / 2^28)
    function automatic longint weigh(longint x, int c);
        logic signed [95:0] xs;
        logic signed [95:0] cs;
        logic signed [95:0] p;
        xs = x;
        cs = c;
        p  = xs * cs;
        return longint'(p >>> 28);
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // accessible fraction of one atom
    function automatic result_t predict_area(int a);
        result_t r;
        longint  surf, v, pair, shared, prod, scd, aij;
        int      ni, nn, bi, bn, nb;
        bit      hit;
        r    = '0;
        surf = surf_mem[a];
        ni   = cnt_mem[a];
        bi   = a * MAX_OVERLAPS;
        if (bur_mem[a]) begin
            v = 0;
        end else if (ni == 0) begin
            v = surf;
        end else if (ni == 1) begin
            v = surf - longint'(area_mem[bi]);
        end else begin
            pair   = 0;
            shared = 0;
            prod   = 0;
            for (int j = 0; j < ni; j++) begin
                aij = area_mem[bi + j];
                nb  = nbr_mem[bi + j];
                bn  = nb * MAX_OVERLAPS;
                nn  = cnt_mem[nb];
                scd = 0;
                pair += aij;
                // areas of the neighbor's slots whose atom is also ours
                for (int k = 0; k < nn; k++) begin
                    hit = 0;
                    for (int l = 0; l < ni; l++)
                        if (nbr_mem[bi + l] == nbr_mem[bn + k]) hit = 1;
                    if (hit) scd += area_mem[bn + k];
                end
                shared += scd;
                scd  = clamp(scd, -64'sd2147483648, SAT31);
                prod += (aij * scd) >>> 16;
            end
            pair   = clamp(pair, 0, SAT31);
            shared = clamp(shared, 0, SAT31);
            prod   = clamp(prod, 0, SAT47);
            bi = type_mem[a] * 4;
            v  = weigh(clamp(surf, 0, SAT31), coef_mem[bi]) + weigh(pair, coef_mem[bi + 1])
               + weigh(shared, coef_mem[bi + 2]) + weigh(prod, coef_mem[bi + 3]);
            r.pair       = pair[SUM31_W-1:0];
            r.shared     = shared[SUM31_W-1:0];
            r.prod       = prod[SUM47_W-1:0];
            r.comp_valid = 1'b1;
        end
        // ratio to the surface, saturated
        if (v <= 0)               r.rel = '0;
        else if (surf == 0)       r.rel = RATIO_TOP[REL_W-1:0];
        else if (surf < 0)        r.rel = '0;
        else if (v >= 2 * surf)   r.rel = RATIO_TOP[REL_W-1:0];
        else                      r.rel = REL_W'((v * 65536) / surf);
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t want;
        cmd_t    c;
        int      a, sl, ty, sel, cn;
        if (!aresetn) begin
            area_q.delete();
        end else begin
            // result side first: it can never belong to an item taken this cycle
            if (m_tvalid && m_tready) begin
                if (area_q.size() == 0) begin
                    $error("result with no compute item waiting: tdata=%h", m_tdata);
                    errors++;
                end else begin
                    want = area_q.pop_front();
                    compared++;
                    if (m_tdata[16:0] !== want.rel) begin
                        $error("relative_area expected %0d got %0d", want.rel, m_tdata[16:0]);
                        errors++;
                    end
                    if (m_tdata[47:17] !== want.pair) begin
                        $error("sum_pair_areas expected %0d got %0d", want.pair, m_tdata[47:17]);
                        errors++;
                    end
                    if (m_tdata[78:48] !== want.shared) begin
                        $error("sum_shared_areas expected %0d got %0d",
                               want.shared, m_tdata[78:48]);
                        errors++;
                    end
                    if (m_tdata[125:79] !== want.prod) begin
                        $error("sum_area_products expected %0d got %0d",
                               want.prod, m_tdata[125:79]);
                        errors++;
                    end
                    if (m_tuser[0] !== want.comp_valid) begin
                        $error("components_valid expected %0d got %0d",
                               want.comp_valid, m_tuser[0]);
                        errors++;
                    end
                end
            end
            // input side: update the mirror or queue a prediction
            if (s_tvalid && s_tready) begin
                c   = cmd_t'(s_tuser);
                a   = s_tdata[9:0];
                sl  = s_tdata[14:10];
                ty  = s_tdata[31:25];
                sel = s_tdata[33:32];
                cn  = s_tdata[72:67];
                case (c)
                    CMD_LOAD_COEF: begin
                        if (ty >= 1 && ty <= TYPE_COUNT)
                            coef_mem[(ty - 1) * 4 + sel] = s_tdata[65:34];
                    end
                    CMD_LOAD_ATOM: begin
                        if (ty < 1) ty = 1;
                        if (ty > TYPE_COUNT) ty = TYPE_COUNT;
                        if (cn > MAX_OVERLAPS) cn = MAX_OVERLAPS;
                        surf_mem[a] = s_tdata[65:34];
                        bur_mem[a]  = s_tdata[66];
                        type_mem[a] = 6'(ty - 1);
                        cnt_mem[a]  = 6'(cn);
                    end
                    CMD_LOAD_SLOT: begin
                        nbr_mem[a * MAX_OVERLAPS + sl]  = s_tdata[24:15];
                        area_mem[a * MAX_OVERLAPS + sl] = s_tdata[65:34];
                    end
                    default: begin
                        area_q.push_back(predict_area(a));
                    end
                endcase
            end
        end
        pending = area_q.size();
    end

endmodule

// ===== tb/tb_lcpo_free_surface_area.sv =====
// top of the lcpo surface area testbench: clock, reset, load and compute stimulus, verdict
`timescale 1ns / 1ps

module tb_lcpo_free_surface_area;
    import lcpo_pkg::*;

    localparam int CYCLE_LIMIT = 5000000;
    localparam int ITEM_TARGET = 540;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [0:0]   m_tuser;

    int  errors, pending, compared;
    int  cycles;
    int  n_items, n_computes;
    bit  no_gaps;
    bit  loaded [1024];
    int  loaded_q[$];

    lcpo_free_surface_area uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    lcpo_free_surface_area_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending), .compared(compared)
    );

    // clock
    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // run limit
    initial cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("lcpo_free_surface_area test failed");
            $finish;
        end
    end

    // idle length: mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure, with long stretches of none
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            m_tready = 1'b1;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(100, 600) : $urandom_range(1, 6))
                @(negedge aclk);
            m_tready = 1'b0;
            repeat (gap_len() + 1) @(negedge aclk);
        end
    end

    task automatic send_item(cmd_t c, int a, int sl, int nb, int ty, int sel,
                             logic [31:0] d, bit b, int cn);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            s_tvalid = 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tdata  = {7'b0, cn[5:0], b, d, sel[1:0], ty[6:0], nb[9:0], sl[4:0], a[9:0]};
        s_tuser  = c;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        n_items++;
        if (c == CMD_COMPUTE) n_computes++;
        if (c == CMD_LOAD_ATOM && !loaded[a]) begin
            loaded[a] = 1;
            loaded_q.push_back(a);
        end
    endtask

    function automatic logic [31:0] rnd_area();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 40 << 16);
        if (r < 93) return -$urandom_range(0, 8 << 16);
        return $urandom;
    endfunction

    function automatic logic [31:0] rnd_surface();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(1 << 16, 150 << 16);
        if (r < 90) return 32'd0;
        return $urandom;
    endfunction

    function automatic logic [31:0] rnd_coef();
        if ($urandom_range(0, 9) == 0) return $urandom;
        return $urandom_range(0, 32'h2000_0000) - 32'h1000_0000;
    endfunction

    // a group of atoms that overlap one another, loaded fully, then each computed
    task automatic run_cluster();
        int members[8];
        int k, ty, ty_in, cn, used;
        bit wide;
        k    = $urandom_range(2, 6);
        wide = ($urandom_range(0, 19) == 0);
        ty   = $urandom_range(1, TYPE_COUNT);
        for (int s = 0; s < 4; s++)
            send_item(CMD_LOAD_COEF, $urandom_range(0, 1023), 0, 0, ty, s, rnd_coef(), 0, 0);
        for (int i = 0; i < k; i++) members[i] = $urandom_range(0, 1023);
        for (int i = 0; i < k; i++) begin
            cn = wide ? $urandom_range(20, 63) : $urandom_range(0, 6);
            // out of range types clamp to the ends, whose coefficients are always loaded
            case ($urandom_range(0, 9))
                0:       ty_in = 0;
                1:       ty_in = $urandom_range(TYPE_COUNT + 1, 127);
                default: ty_in = ty;
            endcase
            send_item(CMD_LOAD_ATOM, members[i], 0, 0, ty_in, $urandom_range(0, 3),
                      rnd_surface(), $urandom_range(0, 9) == 0, cn);
            used = cn > MAX_OVERLAPS ? MAX_OVERLAPS : cn;
            for (int j = 0; j < used; j++)
                send_item(CMD_LOAD_SLOT, members[i], j, members[$urandom_range(0, k - 1)],
                          $urandom_range(0, 127), $urandom_range(0, 3), rnd_area(), 0, 0);
        end
        for (int i = 0; i < k; i++)
            send_item(CMD_COMPUTE, members[i], 0, 0, 0, 0, 0, 0, 0);
    endtask

    initial begin
        int a;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_LOAD_COEF;
        n_items  = 0;
        n_computes = 0;
        no_gaps  = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1'b1;

        // directed: coefficient extremes for the end types, ignored types
        send_item(CMD_LOAD_COEF, 0, 0, 0, 1, 0, 32'h1000_0000, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, 1, 1, 32'hF000_0000, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, 1, 2, 32'h0100_0000, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, 1, 3, 32'h0001_0000, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, TYPE_COUNT, 0, 32'h7FFF_FFFF, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, TYPE_COUNT, 1, 32'h8000_0000, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, TYPE_COUNT, 2, 32'h7FFF_FFFF, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, TYPE_COUNT, 3, 32'h8000_0000, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, 0, 3, 32'hFFFF_FFFF, 0, 0);
        send_item(CMD_LOAD_COEF, 0, 0, 0, 127, 0, 32'h5555_5555, 0, 0);
        // buried atom at the top index, type clamped down to the last
        send_item(CMD_LOAD_ATOM, 1023, 0, 0, 127, 0, 32'h7FFF_FFFF, 1, 0);
        send_item(CMD_COMPUTE, 1023, 0, 0, 0, 0, 0, 0, 0);
        // zero surface with one negative overlap: saturated ratio
        send_item(CMD_LOAD_ATOM, 0, 0, 0, 0, 0, 32'd0, 0, 1);
        send_item(CMD_LOAD_SLOT, 0, 0, 1023, 0, 0, 32'hFFFF_0000, 0, 0);
        send_item(CMD_COMPUTE, 0, 0, 0, 0, 0, 0, 0, 0);
        // negative surface and no overlap
        send_item(CMD_LOAD_ATOM, 1023, 0, 0, 127, 0, 32'h8000_0000, 0, 0);
        send_item(CMD_COMPUTE, 1023, 0, 0, 0, 0, 0, 0, 0);
        // two overlaps: the weighted branch
        send_item(CMD_LOAD_ATOM, 5, 0, 0, 1, 0, 32'h000A_0000, 0, 2);
        send_item(CMD_LOAD_SLOT, 5, 0, 0, 0, 0, 32'h0002_0000, 0, 0);
        send_item(CMD_LOAD_SLOT, 5, 31, 1023, 0, 0, 32'h0001_8000, 0, 0);
        send_item(CMD_LOAD_SLOT, 5, 1, 1023, 0, 0, 32'h0003_0000, 0, 0);
        send_item(CMD_COMPUTE, 5, 0, 0, 0, 0, 0, 0, 0);

        // sender holds off until the block has drained
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);

        // random part: overlapping clusters, with some stray items in between
        while (n_items < ITEM_TARGET) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 99) < 80) begin
                run_cluster();
            end else begin
                a = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
                case ($urandom_range(0, 2))
                    0: send_item(CMD_LOAD_COEF, $urandom_range(0, 1023), 0, 0,
                                 $urandom_range(0, 127), $urandom_range(0, 3), rnd_coef(), 0, 0);
                    1: send_item(CMD_LOAD_SLOT, a, $urandom_range(0, 31),
                                 loaded_q[$urandom_range(0, loaded_q.size() - 1)],
                                 0, 0, rnd_area(), 0, 0);
                    default: send_item(CMD_COMPUTE, a, 0, 0, 0, 0, 0, 0, 0);
                endcase
            end
        end
        s_tvalid = 1'b0;

        // drain, then watch for stray results
        while (pending != 0) @(negedge aclk);
        repeat (2000) @(negedge aclk);

        $display("sent %0d items, %0d of them compute items, over %0d atoms",
                 n_items, n_computes, loaded_q.size());
        $display("compared %0d results under random gaps and back-pressure", compared);
        if (errors == 0)
            $display("lcpo_free_surface_area test passed");
        else
            $display("lcpo_free_surface_area test failed");
        $finish;
    end

endmodule
